// File: rtl/core/detection_box_to_pixel_rect_color_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk with reset arst_n.
// ----------------------------------------------------------------------------
`ifndef DETECTION_BOX_TO_PIXEL_RECT_COLOR_UNIT_DEFINES_SVH
`define DETECTION_BOX_TO_PIXEL_RECT_COLOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define DBRC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("dbrc assertion failed");
`define DBRC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("dbrc implication failed");
`else
`define DBRC_ASSERT(lbl, prop)
`define DBRC_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

// File: rtl/core/dbrc_pkg.sv
// ----------------------------------------------------------------------------
// dbrc_pkg
// Constants, types and shared arithmetic for the box overlay unit.
// ----------------------------------------------------------------------------
package dbrc_pkg;

	localparam int MaxDim    = 4096;
	localparam int ClassMult = 123457;
	localparam int ColorOne  = 32768;
	localparam int Lat       = 14;
	localparam int LwRecip   = 33555;
	localparam int LwShift   = 25;

	typedef enum logic [1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1,
		REG_CLASS_COUNT  = 2'd2,
		REG_NONE         = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [3:0]  q;
		logic [12:0] r;
	} div_res_t;

	function automatic div_res_t div_step4(logic [12:0] r, logic [3:0] b, logic [12:0] d);
		div_res_t    res;
		logic [13:0] t;
		res.r = r;
		res.q = '0;
		for (int k = 3; k >= 0; k--) begin
			t = {res.r, b[k]};
			if (t >= {1'b0, d}) begin
				t = t - {1'b0, d};
				res.q[k] = 1'b1;
			end
			res.r = t[12:0];
		end
		return res;
	endfunction

	// rows magenta, red, yellow, green, cyan, then blue; bits are red, green, blue
	function automatic logic [2:0] hue(logic [2:0] row);
		logic [2:0] v;
		unique case (row)
			3'd0:    v = 3'b101;
			3'd1:    v = 3'b100;
			3'd2:    v = 3'b110;
			3'd3:    v = 3'b010;
			3'd4:    v = 3'b011;
			default: v = 3'b001;
		endcase
		return v;
	endfunction

endpackage

// File: rtl/core/dbrc_color.sv
// ----------------------------------------------------------------------------
// dbrc_color
// Class colour pipeline: modulo, ratio split and fraction division.
// ----------------------------------------------------------------------------
module dbrc_color (
	input  logic        clk,
	input  logic [9:0]  class_idx,
	input  logic [10:0] class_count,
	output logic [15:0] color_red,
	output logic [15:0] color_green,
	output logic [15:0] color_blue
);

	logic [10:0] n_eff;
	logic [27:0] dv [0:7];
	logic [12:0] rm [1:7];
	logic [12:0] fr [0:4];
	logic [15:0] fn [0:4];
	logic [15:0] fq [0:4];
	logic [2:0]  fi [0:4];
	logic        fz [0:4];
	logic [13:0] num;
	logic [13:0] n1, n2, n4;
	logic [13:0] t1, t2, t3;
	logic [2:0]  iq;
	logic [12:0] d2;
	logic [2:0]  ha, hb, jrow;
	logic [15:0] ch [0:2];

	assign n_eff = (class_count == '0) ? 11'd1 : class_count;
	assign d2    = {1'b0, n_eff, 1'b0};

	always_ff @(posedge clk) begin
		dv[0] <= {1'b0, 27'({17'b0, class_idx} * 27'(dbrc_pkg::ClassMult))};
	end

	for (genvar k = 1; k <= 7; k++) begin : g_mod
		dbrc_pkg::div_res_t mres;
		if (k == 1) begin : g_first
			assign mres = dbrc_pkg::div_step4('0, dv[0][27:24], {2'b0, n_eff});
		end else begin : g_rest
			assign mres = dbrc_pkg::div_step4(rm[k-1], dv[k-1][27:24], {2'b0, n_eff});
		end
		always_ff @(posedge clk) begin
			rm[k] <= mres.r;
			dv[k] <= dv[k-1] << 4;
		end
	end

	always_comb begin
		num = {3'b0, rm[7][10:0]} * 14'd5;
		n1  = {3'b0, n_eff};
		n2  = {2'b0, n_eff, 1'b0};
		n4  = {1'b0, n_eff, 2'b0};
		iq  = '0;
		t1  = num;
		if (t1 >= n4) begin
			t1 = t1 - n4;
			iq[2] = 1'b1;
		end
		t2 = t1;
		if (t2 >= n2) begin
			t2 = t2 - n2;
			iq[1] = 1'b1;
		end
		t3 = t2;
		if (t3 >= n1) begin
			t3 = t3 - n1;
			iq[0] = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		fr[0] <= t3[12:0];
		fn[0] <= {5'b0, n_eff};
		fq[0] <= '0;
		fi[0] <= iq;
		fz[0] <= (t3 == '0);
	end

	for (genvar k = 1; k <= 4; k++) begin : g_frac
		dbrc_pkg::div_res_t fres;
		assign fres = dbrc_pkg::div_step4(fr[k-1], fn[k-1][15:12], d2);
		always_ff @(posedge clk) begin
			fr[k] <= fres.r;
			fn[k] <= fn[k-1] << 4;
			fq[k] <= {fq[k-1][11:0], fres.q};
			fi[k] <= fi[k-1];
			fz[k] <= fz[k-1];
		end
	end

	always_comb begin
		jrow = fz[4] ? fi[4] : fi[4] + 3'd1;
		ha   = dbrc_pkg::hue(fi[4]);
		hb   = dbrc_pkg::hue(jrow);
		for (int c = 0; c < 3; c++) begin
			if (ha[2-c] && hb[2-c])
				ch[c] = 16'(dbrc_pkg::ColorOne);
			else if (ha[2-c])
				ch[c] = 16'(dbrc_pkg::ColorOne) - fq[4];
			else if (hb[2-c])
				ch[c] = fq[4];
			else
				ch[c] = '0;
		end
	end

	always_ff @(posedge clk) begin
		color_red   <= ch[0];
		color_green <= ch[1];
		color_blue  <= ch[2];
	end

endmodule

// File: rtl/core/detection_box_to_pixel_rect_color_unit.sv
// ----------------------------------------------------------------------------
// detection_box_to_pixel_rect_color_unit
// Overlay rectangle, line width and class colour for one detection.
// ----------------------------------------------------------------------------
// Usage:
//   Present a detection on the box and class ports with start high; it is
//   taken at that edge. busy stays low, so an item may enter every cycle.
//   The result appears on the rect, line_width and colour
//   ports for one cycle with done high; one item per cycle sustained.
//   Latency is set by the class colour path: a 28-bit modulo over seven
//   stages and a 16-bit fraction division over four, four bits a stage.
//   Configuration uses cfg_valid/cfg_ready with cfg_index and cfg_data;
//   cfg_ready is always high. Write only while no item is in flight.
//   Reset clears the pipeline valid bits and loads 1920 x 1080 and
//   80 classes. The receiver cannot stall: done is a one-cycle strobe.
// ----------------------------------------------------------------------------
`include "detection_box_to_pixel_rect_color_unit_defines.svh"

module detection_box_to_pixel_rect_color_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [17:0] box_center_x,
	input  logic signed [17:0] box_center_y,
	input  logic        [16:0] box_width,
	input  logic        [16:0] box_height,
	input  logic        [9:0]  class_idx,
	output logic               done,
	output logic        [11:0] rect_left,
	output logic        [11:0] rect_right,
	output logic        [11:0] rect_top,
	output logic        [11:0] rect_bottom,
	output logic        [4:0]  line_width,
	output logic        [15:0] color_red,
	output logic        [15:0] color_green,
	output logic        [15:0] color_blue,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic        [1:0]  cfg_index,
	input  logic        [12:0] cfg_data
);

	localparam int L = dbrc_pkg::Lat;

	logic [12:0] image_width_q, image_height_q;
	logic [10:0] class_count_q;
	logic [12:0] w_eff, h_eff;
	logic [4:0]  lw_q;
	logic [30:0] lw_prod;
	logic        vld [1:L];

	logic signed [20:0] e_s1 [0:3];
	logic signed [34:0] p_s2 [0:3];
	logic        [11:0] r_d  [3:L][0:3];
	logic        [11:0] e_clamp [0:3];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= 13'd1920;
			image_height_q <= 13'd1080;
			class_count_q  <= 11'd80;
		end else if (cfg_valid && cfg_ready) begin
			unique case (dbrc_pkg::reg_idx_t'(cfg_index))
				dbrc_pkg::REG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				dbrc_pkg::REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				dbrc_pkg::REG_CLASS_COUNT:  class_count_q  <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	assign w_eff = (image_width_q == '0) ? 13'd1 :
		(image_width_q > 13'(dbrc_pkg::MaxDim)) ? 13'(dbrc_pkg::MaxDim) : image_width_q;
	assign h_eff = (image_height_q == '0) ? 13'd1 :
		(image_height_q > 13'(dbrc_pkg::MaxDim)) ? 13'(dbrc_pkg::MaxDim) : image_height_q;

	assign lw_prod = 31'({h_eff, 2'b0} + {1'b0, h_eff, 1'b0}) * 31'(dbrc_pkg::LwRecip);

	always_ff @(posedge clk) begin
		lw_q <= (lw_prod[30:dbrc_pkg::LwShift] == '0) ? 5'd1 : lw_prod[29:dbrc_pkg::LwShift];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= L; k++) vld[k] <= 1'b0;
		end else begin
			vld[1] <= start && !busy;
			for (int k = 2; k <= L; k++) vld[k] <= vld[k-1];
		end
	end

	always_ff @(posedge clk) begin
		e_s1[0] <= 21'(signed'({box_center_x, 1'b0})) - 21'(signed'({1'b0, box_width}));
		e_s1[1] <= 21'(signed'({box_center_x, 1'b0})) + 21'(signed'({1'b0, box_width}));
		e_s1[2] <= 21'(signed'({box_center_y, 1'b0})) - 21'(signed'({1'b0, box_height}));
		e_s1[3] <= 21'(signed'({box_center_y, 1'b0})) + 21'(signed'({1'b0, box_height}));
		p_s2[0] <= 35'(e_s1[0]) * 35'(signed'({1'b0, w_eff}));
		p_s2[1] <= 35'(e_s1[1]) * 35'(signed'({1'b0, w_eff}));
		p_s2[2] <= 35'(e_s1[2]) * 35'(signed'({1'b0, h_eff}));
		p_s2[3] <= 35'(e_s1[3]) * 35'(signed'({1'b0, h_eff}));
	end

	always_comb begin
		for (int e = 0; e < 4; e++) begin
			logic [12:0] lim;
			lim = (e < 2) ? w_eff - 13'd1 : h_eff - 13'd1;
			if (p_s2[e] <= 0)
				e_clamp[e] = '0;
			else if (p_s2[e][34:17] > 18'(lim))
				e_clamp[e] = lim[11:0];
			else
				e_clamp[e] = p_s2[e][28:17];
		end
	end

	always_ff @(posedge clk) begin
		r_d[3] <= e_clamp;
		for (int k = 4; k <= L; k++) r_d[k] <= r_d[k-1];
	end

	dbrc_color u_color (
		.clk         (clk),
		.class_idx   (class_idx),
		.class_count (class_count_q),
		.color_red   (color_red),
		.color_green (color_green),
		.color_blue  (color_blue)
	);

	assign done        = vld[L];
	assign rect_left   = r_d[L][0];
	assign rect_right  = r_d[L][1];
	assign rect_top    = r_d[L][2];
	assign rect_bottom = r_d[L][3];
	assign line_width  = lw_q;

	`DBRC_ASSERT(a_latency, start |-> ##14 done)
	`DBRC_ASSERT_IMP(a_lw_nonzero, done, line_width != 5'd0)
	`DBRC_ASSERT_IMP(a_red_range, done, color_red <= 16'd32768)

endmodule
